/* hw/rtl/bdls_pkg.sv */
package bdls_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int LOD_FRAC_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DEPTH_W    = 5;
    localparam int DIST_W     = 32;
    localparam int LEVEL_W    = 13;
    localparam int LEVEL_MAX  = 4095;
    localparam int MANT_W     = 32;
    localparam int MANT_FRAC  = 31;

    localparam logic [CFG_IDX_W-1:0] REG_TREE_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_DIST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_DIST   = 2'd2;

    localparam logic [DEPTH_W-1:0] DEPTH_RST = 5'd1;
    localparam logic [DIST_W-1:0]  DIST_RST  = 32'h0001_0000;

    typedef enum logic {
        KIND_MESH    = 1'b0,
        KIND_TEXTURE = 1'b1
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  above;
    } ctrl_t;

endpackage

/* hw/rtl/bdls_sqrt_cell.sv */
module bdls_sqrt_cell
    import bdls_pkg::*;
#(
    parameter int RW = 35
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  ctrl_t           ctrl_in,
    input  logic [RW+1:0]   rem_in,
    input  logic [RW-1:0]   root_in,
    input  logic [2*RW-1:0] rad_in,
    output ctrl_t           ctrl_out,
    output logic [RW+1:0]   rem_out,
    output logic [RW-1:0]   root_out,
    output logic [2*RW-1:0] rad_out
);

    ctrl_t           ctrl_reg;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [2*RW-1:0] rad_reg;
    logic [RW+3:0]   rem_sh, trial, diff;
    logic            take;

    always_comb begin
        rem_sh    = {rem_in, rad_in[2*RW-1 -: 2]};
        trial     = {2'b00, root_in, 2'b01};
        diff      = rem_sh - trial;
        take      = (rem_sh >= trial);
        rem_next  = take ? diff[RW+1:0] : rem_sh[RW+1:0];
        root_next = {root_in[RW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= {rad_in[2*RW-3:0], 2'b00};
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

/* hw/rtl/bdls_div_cell.sv */
module bdls_div_cell
    import bdls_pkg::*;
#(
    parameter int NW = 34,
    parameter int QW = 65
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  ctrl_t             ctrl_in,
    input  logic [DIST_W-1:0] rem_in,
    input  logic [NW-1:0]     num_in,
    input  logic [QW-1:0]     quo_in,
    input  logic [DIST_W-1:0] div_in,
    output ctrl_t             ctrl_out,
    output logic [DIST_W-1:0] rem_out,
    output logic [NW-1:0]     num_out,
    output logic [QW-1:0]     quo_out,
    output logic [DIST_W-1:0] div_out
);

    ctrl_t             ctrl_reg;
    logic [DIST_W-1:0] rem_reg, rem_next, div_reg;
    logic [NW-1:0]     num_reg;
    logic [QW-1:0]     quo_reg;
    logic [DIST_W:0]   t, diff;
    logic              take;

    always_comb begin
        t        = {rem_in, num_in[NW-1]};
        diff     = t - {1'b0, div_in};
        take     = (t >= {1'b0, div_in});
        rem_next = take ? diff[DIST_W-1:0] : t[DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            num_reg <= {num_in[NW-2:0], 1'b0};
            quo_reg <= {quo_in[QW-2:0], take};
            div_reg <= div_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign num_out  = num_reg;
    assign quo_out  = quo_reg;
    assign div_out  = div_reg;

endmodule

/* hw/rtl/bdls_sq_cell.sv */
module bdls_sq_cell
    import bdls_pkg::*;
#(
    parameter int FW = 8,
    parameter int IW = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  ctrl_t             ctrl_in,
    input  logic [MANT_W-1:0] m_in,
    input  logic [FW-1:0]     frac_in,
    input  logic [IW-1:0]     ip_in,
    output ctrl_t             ctrl_out,
    output logic [MANT_W-1:0] m_out,
    output logic [FW-1:0]     frac_out,
    output logic [IW-1:0]     ip_out
);

    ctrl_t               ctrl_reg;
    logic [MANT_W-1:0]   m_reg, m_next;
    logic [FW-1:0]       frac_reg;
    logic [IW-1:0]       ip_reg;
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]     t;
    logic [FW:0]         frac_sh;

    always_comb begin
        prod    = m_in * m_in;
        t       = prod[2*MANT_W-1 -: MANT_W+1];
        m_next  = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
        frac_sh = {frac_in, t[MANT_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg    <= m_next;
            frac_reg <= frac_sh[FW-1:0];
            ip_reg   <= ip_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign m_out    = m_reg;
    assign frac_out = frac_reg;
    assign ip_out   = ip_reg;

endmodule

/* hw/rtl/box_distance_lod_select.sv */
// Box distance LOD selector.
// s_ channel: one word per request, a box and a view point in Q16.16;
//   s_tuser selects the mesh level (0) or the texture level (1).
// m_ channel: one word per request, in request order; m_tdata carries the
//   signed level, m_tuser echoes the request kind.
// cfg channel: cfg_index 0 tree depth, 1 mesh distance, 2 texture distance;
//   always ready; to be written by the user while no request is in flight (unchecked).
// Throughput: one word per cycle while the output is not stalled. The pipe
//   includes a bit-serial square root row of COORD_WIDTH+3 cells, a divide
//   row of COORD_WIDTH+33 cells, a shift normalizer and a row of
//   LOD_FRAC_BITS squaring cells.
// Back pressure: when m_tvalid is high and m_tready low the whole pipe
//   holds and s_tready drops until the output word is taken.
// Reset clears all valid bits and loads depth 1 and both distances 1.0.
module box_distance_lod_select
    import bdls_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int LOD_FRAC_BITS = LOD_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // view_x, view_y, view_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // lod_level
    output logic [((LEVEL_W+7)/8)*8-1:0] m_tdata,
    // level_kind
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = LOD_FRAC_BITS;
    localparam int GW    = CW + 2;
    localparam int RW    = GW + 1;
    localparam int SW    = 2 * RW;
    localparam int NW    = GW;
    localparam int QW    = NW + MANT_FRAC;
    localparam int NST   = $clog2(QW);
    localparam int FW    = (FB > 0) ? FB : 1;
    localparam int TW    = NST + FB;
    localparam int CMPW  = (NW > DIST_W) ? NW : DIST_W;
    localparam int VW0   = ((DEPTH_W > NST) ? DEPTH_W : NST) + FB + 2;
    localparam int VW    = (VW0 > LEVEL_W + 1) ? VW0 : LEVEL_W + 1;
    localparam int OUT_W = ((LEVEL_W + 7) / 8) * 8;

    logic [DEPTH_W-1:0] depth_reg;
    logic [DIST_W-1:0]  mesh_dist_reg, tex_dist_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= DEPTH_RST;
            mesh_dist_reg <= DIST_RST;
            tex_dist_reg  <= DIST_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TREE_DEPTH: depth_reg     <= cfg_data[DEPTH_W-1:0];
                REG_MESH_DIST:  mesh_dist_reg <= cfg_data[DIST_W-1:0];
                REG_TEX_DIST:   tex_dist_reg  <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    logic m_tvalid_reg;
    logic adv;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    function automatic logic [GW-1:0] axis_gap(input logic [CW-1:0] mn,
                                               input logic [CW-1:0] mx,
                                               input logic [CW-1:0] v);
        logic signed [CW+2:0] a, ext, g;
        a   = ($signed({{3{v[CW-1]}}, v}) <<< 1) - $signed({{3{mn[CW-1]}}, mn})
              - $signed({{3{mx[CW-1]}}, mx});
        if (a < 0) begin
            a = -a;
        end
        ext = $signed({{3{mx[CW-1]}}, mx}) - $signed({{3{mn[CW-1]}}, mn});
        g   = a - ext;
        return (g > 0) ? g[GW-1:0] : '0;
    endfunction

    // gap, square and sum stages
    ctrl_t          c0_reg, c1_reg, c2_reg;
    logic [GW-1:0]  gx_reg, gy_reg, gz_reg;
    logic [2*GW-1:0] px_reg, py_reg, pz_reg;
    logic [SW-1:0]  sum_reg;
    ctrl_t          c_in;

    always_comb begin
        c_in.valid = s_tvalid;
        c_in.kind  = kind_t'(s_tuser);
        c_in.above = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
        end else if (adv) begin
            c0_reg <= c_in;
            c1_reg <= c0_reg;
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            gx_reg  <= axis_gap(s_tdata[0*CW +: CW], s_tdata[3*CW +: CW],
                                s_tdata[6*CW +: CW]);
            gy_reg  <= axis_gap(s_tdata[1*CW +: CW], s_tdata[4*CW +: CW],
                                s_tdata[7*CW +: CW]);
            gz_reg  <= axis_gap(s_tdata[2*CW +: CW], s_tdata[5*CW +: CW],
                                s_tdata[8*CW +: CW]);
            px_reg  <= gx_reg * gx_reg;
            py_reg  <= gy_reg * gy_reg;
            pz_reg  <= gz_reg * gz_reg;
            sum_reg <= SW'(px_reg) + SW'(py_reg) + SW'(pz_reg);
        end
    end

    // square root row
    ctrl_t         sr_ctrl [RW+1];
    logic [RW+1:0] sr_rem  [RW+1];
    logic [RW-1:0] sr_root [RW+1];
    logic [SW-1:0] sr_rad  [RW+1];

    assign sr_ctrl[0] = c2_reg;
    assign sr_rem[0]  = '0;
    assign sr_root[0] = '0;
    assign sr_rad[0]  = sum_reg;

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        bdls_sqrt_cell #(.RW(RW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .ctrl_in  (sr_ctrl[i]),
            .rem_in   (sr_rem[i]),
            .root_in  (sr_root[i]),
            .rad_in   (sr_rad[i]),
            .ctrl_out (sr_ctrl[i+1]),
            .rem_out  (sr_rem[i+1]),
            .root_out (sr_root[i+1]),
            .rad_out  (sr_rad[i+1])
        );
    end

    // divide entry
    logic [NW-1:0]     dist_val;
    logic [DIST_W-1:0] lsel, lnz;
    ctrl_t             cd_in, cd_reg;
    logic [NW-1:0]     dnum_reg;
    logic [DIST_W-1:0] ddiv_reg;

    always_comb begin
        dist_val = sr_root[RW][RW-1:1];
        lsel     = (sr_ctrl[RW].kind == KIND_MESH) ? mesh_dist_reg : tex_dist_reg;
        lnz      = (lsel == '0) ? DIST_W'(1) : lsel;
        cd_in    = sr_ctrl[RW];
        cd_in.above = (CMPW'(dist_val) > CMPW'(lnz));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cd_reg <= '0;
        end else if (adv) begin
            cd_reg <= cd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dnum_reg <= dist_val;
            ddiv_reg <= lnz;
        end
    end

    // divide row: quotient of the distance * 2^31 by the distance register
    ctrl_t             dv_ctrl [QW+1];
    logic [DIST_W-1:0] dv_rem  [QW+1];
    logic [NW-1:0]     dv_num  [QW+1];
    logic [QW-1:0]     dv_quo  [QW+1];
    logic [DIST_W-1:0] dv_div  [QW+1];

    assign dv_ctrl[0] = cd_reg;
    assign dv_rem[0]  = '0;
    assign dv_num[0]  = dnum_reg;
    assign dv_quo[0]  = '0;
    assign dv_div[0]  = ddiv_reg;

    for (genvar i = 0; i < QW; i++) begin : g_div
        bdls_div_cell #(.NW(NW), .QW(QW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .ctrl_in  (dv_ctrl[i]),
            .rem_in   (dv_rem[i]),
            .num_in   (dv_num[i]),
            .quo_in   (dv_quo[i]),
            .div_in   (dv_div[i]),
            .ctrl_out (dv_ctrl[i+1]),
            .rem_out  (dv_rem[i+1]),
            .num_out  (dv_num[i+1]),
            .quo_out  (dv_quo[i+1]),
            .div_out  (dv_div[i+1])
        );
    end

    // normalizer: leading zero count by halving shifts
    ctrl_t          nz_ctrl [NST+1];
    logic [QW-1:0]  nz_q    [NST+1];
    logic [NST-1:0] nz_cnt  [NST+1];

    assign nz_ctrl[0] = dv_ctrl[QW];
    assign nz_q[0]    = dv_quo[QW];
    assign nz_cnt[0]  = '0;

    for (genvar j = 0; j < NST; j++) begin : g_norm
        localparam int SH = 2 ** (NST - 1 - j);
        ctrl_t          ctrl_reg;
        logic [QW-1:0]  q_reg;
        logic [NST-1:0] cnt_reg, cnt_next;
        logic           zero_top;

        always_comb begin
            zero_top = (nz_q[j][QW-1 -: SH] == '0);
            cnt_next = nz_cnt[j];
            cnt_next[NST-1-j] = zero_top;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_reg <= '0;
            end else if (adv) begin
                ctrl_reg <= nz_ctrl[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                q_reg   <= zero_top ? (nz_q[j] << SH) : nz_q[j];
                cnt_reg <= cnt_next;
            end
        end

        assign nz_ctrl[j+1] = ctrl_reg;
        assign nz_q[j+1]    = q_reg;
        assign nz_cnt[j+1]  = cnt_reg;
    end

    // squaring row for the fraction bits
    ctrl_t             sc_ctrl [FB+1];
    logic [MANT_W-1:0] sc_m    [FB+1];
    logic [FW-1:0]     sc_frac [FB+1];
    logic [NST-1:0]    sc_ip   [FB+1];

    assign sc_ctrl[0] = nz_ctrl[NST];
    assign sc_m[0]    = nz_q[NST][QW-1 -: MANT_W];
    assign sc_frac[0] = '0;
    assign sc_ip[0]   = nz_ctrl[NST].above ? (NST'(QW - MANT_W) - nz_cnt[NST]) : '0;

    for (genvar k = 0; k < FB; k++) begin : g_sq
        bdls_sq_cell #(.FW(FW), .IW(NST)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .ctrl_in  (sc_ctrl[k]),
            .m_in     (sc_m[k]),
            .frac_in  (sc_frac[k]),
            .ip_in    (sc_ip[k]),
            .ctrl_out (sc_ctrl[k+1]),
            .m_out    (sc_m[k+1]),
            .frac_out (sc_frac[k+1]),
            .ip_out   (sc_ip[k+1])
        );
    end

    // level and output register
    ctrl_t              c_end;
    logic [FW-1:0]      frac_end;
    logic [TW-1:0]      total;
    logic signed [VW-1:0] lvl_m, lvl_t;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    assign c_end    = sc_ctrl[FB];
    assign frac_end = c_end.above ? sc_frac[FB] : '0;

    if (FB > 0) begin : g_total_frac
        assign total = {sc_ip[FB], frac_end};
    end else begin : g_total_int
        assign total = sc_ip[FB] | NST'(frac_end);
    end

    always_comb begin
        lvl_m = $signed(VW'(depth_reg) << FB) - $signed(VW'(1)) - $signed(VW'(total));
        lvl_t = $signed(VW'(depth_reg)) - $signed(VW'(1)) - $signed(VW'(sc_ip[FB]));
        if (c_end.kind == KIND_MESH) begin
            if (lvl_m < 0) begin
                level = '0;
            end else if (lvl_m > $signed(VW'(LEVEL_MAX))) begin
                level = LEVEL_W'(LEVEL_MAX);
            end else begin
                level = lvl_m[LEVEL_W-1:0];
            end
        end else begin
            level = lvl_t[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= c_end.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= level;
            m_tuser_reg <= c_end.kind;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(m_tdata_reg);
    assign m_tuser  = m_tuser_reg;

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(s_tvalid && s_tready))
        else $error("word accepted while output stalled");

    a_mesh_level_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == 1'(KIND_MESH)) |-> !m_tdata[LEVEL_W-1])
        else $error("mesh level out of range");

    a_norm_msb: assert property (@(posedge aclk) disable iff (!aresetn)
        (nz_ctrl[NST].valid && nz_ctrl[NST].above) |-> nz_q[NST][QW-1])
        else $error("quotient not normalized");

endmodule

/* tb/tb_box_distance_lod_select.sv */
`timescale 1ns / 100ps

module tb_box_distance_lod_select;
    import bdls_pkg::*;

    localparam int CW       = 32;
    localparam int FB       = 8;
    localparam int LATENCY  = 2*CW + 41 + $clog2(CW+33) + FB;
    localparam int SDATA_W  = ((9*CW+7)/8)*8;
    localparam int MDATA_W  = ((LEVEL_W+7)/8)*8;

    typedef logic [CW-1:0] coord_set_t [9];

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SDATA_W-1:0]    s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [MDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    box_distance_lod_select dut (.*);

    // local copy of the registers
    logic [DEPTH_W-1:0] depth_q;
    logic [DIST_W-1:0]  mesh_dist_q;
    logic [DIST_W-1:0]  tex_dist_q;

    logic [LEVEL_W-1:0] level_fifo [$];
    kind_t              kind_fifo [$];

    int errors = 0;
    int send_idle_pct;
    int recv_stall_pct;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    initial begin
        #(12 * 400000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] axis_gap2(logic [CW-1:0] lo, logic [CW-1:0] hi,
                                              logic [CW-1:0] v);
        longint mn, mx, vp, a, g;
        mn = longint'($signed(lo));
        mx = longint'($signed(hi));
        vp = longint'($signed(v));
        a = 2*vp - mn - mx;
        if (a < 0) a = -a;
        g = a - (mx - mn);
        return (g > 0) ? 64'(g) : 64'd0;
    endfunction

    function automatic logic [63:0] box_distance(coord_set_t c);
        logic [63:0]  g [3];
        logic [127:0] s;
        logic [127:0] cand;
        logic [63:0]  r;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            g[i] = axis_gap2(c[i], c[i+3], c[i+6]);
            s += 128'(g[i]) * 128'(g[i]);
        end
        r = '0;
        for (int i = 40; i >= 0; i--) begin
            cand = 128'(r | (64'd1 << i));
            if (cand * cand <= s) r = r | (64'd1 << i);
        end
        return r >> 1;
    endfunction

    // floor(2^FB * log2(max(1, d/L))), integer part in ipart
    function automatic logic [63:0] log2_ratio(logic [63:0] d, logic [63:0] lod_dist,
                                               output logic [63:0] ipart);
        logic [63:0] n, base, rem, m, frac;
        n = 0; m = 1; frac = 0; ipart = 0;
        if (lod_dist == 0) lod_dist = 1;
        if (d <= lod_dist) return 0;
        while (n < 62 && (lod_dist << (n + 1)) <= d) n++;
        base = lod_dist << n;
        rem = d - base;
        for (int i = 0; i < 31; i++) begin
            rem = rem << 1;
            m = m << 1;
            if (rem >= base) begin
                rem -= base;
                m |= 1;
            end
        end
        for (int i = 0; i < FB; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac |= 1;
                m = m >> 1;
            end
        end
        ipart = n;
        return (n << FB) | frac;
    endfunction

    function automatic logic [LEVEL_W-1:0] predict_level(kind_t k, coord_set_t c);
        logic [63:0] d, total, ip;
        longint lvl;
        d = box_distance(c);
        if (k == KIND_MESH) begin
            total = log2_ratio(d, 64'(mesh_dist_q), ip);
            lvl = (longint'(depth_q) << FB) - 1 - longint'(total);
            if (lvl < 0) lvl = 0;
            if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
        end else begin
            total = log2_ratio(d, 64'(tex_dist_q), ip);
            lvl = longint'(depth_q) - 1 - longint'(ip);
        end
        return lvl[LEVEL_W-1:0];
    endfunction

    task automatic send_box(kind_t k, coord_set_t c);
        logic acc;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        for (int i = 0; i < 9; i++) s_tdata[CW*i +: CW] <= c[i];
        do begin
            @(negedge aclk);
            acc = s_tready;
            @(posedge aclk);
        end while (!acc);
        level_fifo.push_back(predict_level(k, c));
        kind_fifo.push_back(k);
    endtask

    task automatic stop_send();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (level_fifo.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        logic acc;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
            acc = cfg_ready;
            @(posedge aclk);
        end while (!acc);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_TREE_DEPTH: depth_q     = val[DEPTH_W-1:0];
            REG_MESH_DIST:  mesh_dist_q = val;
            REG_TEX_DIST:   tex_dist_q  = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] depth, logic [31:0] md, logic [31:0] td);
        write_reg(REG_TREE_DEPTH, depth);
        write_reg(REG_MESH_DIST, md);
        write_reg(REG_TEX_DIST, td);
    endtask

    // point box at the origin with a view on the x axis
    task automatic send_point(kind_t k, logic [CW-1:0] vx);
        coord_set_t c;
        foreach (c[i]) c[i] = '0;
        c[6] = vx;
        send_box(k, c);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        int sh;
        sh = $urandom_range(0, 31);
        return CW'($signed($urandom) >>> sh);
    endfunction

    task automatic send_random_box();
        coord_set_t c;
        kind_t k;
        logic [CW-1:0] ctr, half, off;
        k = kind_t'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
            foreach (c[i]) c[i] = $urandom;
        end else begin
            for (int a = 0; a < 3; a++) begin
                ctr  = rand_coord();
                half = rand_coord() >>> 1;
                if (half[CW-1] && $urandom_range(0, 19) != 0) half = -half;
                off  = rand_coord();
                c[a]   = ctr - half;
                c[a+3] = ctr + half;
                c[a+6] = ctr + off;
            end
        end
        send_box(k, c);
    endtask

    task automatic test_directed();
        coord_set_t c;
        send_point(KIND_MESH, 32'd0);
        send_point(KIND_TEXTURE, 32'd0);
        send_point(KIND_MESH, 32'h0001_0000);
        send_point(KIND_MESH, 32'h0001_0001);
        send_point(KIND_TEXTURE, 32'h0002_0000);
        send_point(KIND_TEXTURE, 32'h0001_ffff);
        send_point(KIND_MESH, 32'h7fff_ffff);
        send_point(KIND_TEXTURE, 32'h8000_0000);
        send_point(KIND_MESH, 32'h0003_0000);
        // degenerate box with both corners at the most negative value, view outside on all axes
        for (int i = 0; i < 3; i++) begin
            c[i] = 32'h8000_0000; c[i+3] = 32'h8000_0000; c[i+6] = 32'h7fff_ffff;
        end
        send_box(KIND_MESH, c);
        send_box(KIND_TEXTURE, c);
        // full range box, view inside
        for (int i = 0; i < 3; i++) begin
            c[i] = 32'h8000_0000; c[i+3] = 32'h7fff_ffff; c[i+6] = 32'hffff_ffff;
        end
        send_box(KIND_MESH, c);
        // inverted box
        for (int i = 0; i < 3; i++) begin
            c[i] = 32'h7fff_ffff; c[i+3] = 32'h8000_0000; c[i+6] = 32'h0;
        end
        send_box(KIND_MESH, c);
        send_box(KIND_TEXTURE, c);
        for (int i = 0; i < 3; i++) begin
            c[i] = 32'h0004_0000; c[i+3] = 32'h0001_0000; c[i+6] = 32'h0002_8000;
        end
        send_box(KIND_TEXTURE, c);
        stop_send();
        wait_drained();
        // zero distances, zero depth, then max depth and distances
        set_regs(32'd0, 32'd0, 32'd0);
        send_point(KIND_MESH, 32'h0000_0002);
        send_point(KIND_TEXTURE, 32'h0000_0002);
        send_point(KIND_TEXTURE, 32'h7fff_ffff);
        stop_send();
        wait_drained();
        set_regs(32'd31, 32'hffff_ffff, 32'hffff_ffff);
        send_point(KIND_MESH, 32'h7fff_ffff);
        send_point(KIND_TEXTURE, 32'h8000_0000);
        stop_send();
        wait_drained();
        set_regs(32'd16, 32'd1, 32'd1);
        send_point(KIND_MESH, 32'h7fff_ffff);
        send_point(KIND_TEXTURE, 32'h8000_0000);
        send_point(KIND_MESH, 32'h0000_0001);
        stop_send();
        wait_drained();
    endtask

    task automatic test_random_traffic(int n_items);
        for (int i = 0; i < n_items; i++) begin
            send_random_box();
            if (i == n_items / 2) begin
                stop_send();
                while (level_fifo.size() != 0) @(posedge aclk);
            end
        end
        stop_send();
        wait_drained();
    endtask

    task automatic test_register_sweep();
        int idle_s [3] = '{13, 82, 0};
        int idle_r [3] = '{82, 13, 0};
        for (int p = 0; p < 3; p++) begin
            send_idle_pct  = idle_s[p];
            recv_stall_pct = idle_r[p];
            set_regs($urandom_range(1, 16), $urandom >> $urandom_range(0, 24),
                     $urandom >> $urandom_range(0, 24));
            test_random_traffic(290);
            set_regs($urandom_range(0, 31), $urandom, $urandom);
            test_random_traffic(290);
        end
        set_regs(32'd1, 32'h0001_0000, 32'h0001_0000);
        test_random_traffic(40);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (level_fifo.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: level %0d kind %0d",
                                 $signed(m_tdata[LEVEL_W-1:0]), m_tuser);
                end else begin
                    if (m_tdata[LEVEL_W-1:0] !== level_fifo[0] ||
                        m_tuser !== kind_fifo[0]) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp level %0d kind %0d, got level %0d kind %0d",
                                     $signed(level_fifo[0]), kind_fifo[0],
                                     $signed(m_tdata[LEVEL_W-1:0]), m_tuser);
                    end
                    void'(level_fifo.pop_front());
                    void'(kind_fifo.pop_front());
                end
            end
        end
    end

    initial begin
        send_idle_pct  = 13;
        recv_stall_pct = 82;
        depth_q        = DEPTH_RST;
        mesh_dist_q    = DIST_RST;
        tex_dist_q     = DIST_RST;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_sweep();
        if (errors == 0 && level_fifo.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
